FILE: src/ihf_pkg.sv
package ihf_pkg;

  localparam int unsigned MaxRecordBytes     = 32;
  localparam int unsigned DefaultRecordBytes = 16;
  localparam int unsigned CountW             = 6;
  localparam int unsigned IndexW             = 5;
  localparam int unsigned PosW               = 6;
  localparam int unsigned MaxResults         = 40;
  localparam int unsigned ResultCntW         = 6;
  localparam int unsigned QueueAw            = 1;

  localparam logic [7:0] RecTypeData      = 8'h00;
  localparam logic [7:0] RecTypeEof       = 8'h01;
  localparam logic [7:0] RecTypeExtLinear = 8'h04;
  localparam logic [7:0] ExtPayloadBytes  = 8'h02;
  localparam logic [PosW-1:0] RecHeadBytes = PosW'(4);

  typedef struct packed {
    logic        func;
    logic [31:0] byte_address;
    logic [7:0]  data_byte;
  } ihf_in_t;

  typedef struct packed {
    logic [7:0] record_byte;
    logic       record_start;
    logic       last;
  } ihf_out_t;

  // One classified item: which records to emit around the buffer write.
  typedef struct packed {
    logic              hdr;
    logic              fa;
    logic              ext_a;
    logic [15:0]       upper_a;
    logic [15:0]       addr_a;
    logic [CountW-1:0] cnt_a;
    logic              wr;
    logic [IndexW-1:0] wr_idx;
    logic [7:0]        data;
    logic              fb;
    logic              ext_b;
    logic [15:0]       upper_b;
    logic [15:0]       addr_b;
    logic [CountW-1:0] cnt_b;
    logic              eof;
  } ihf_cmd_t;

endpackage

FILE: src/ihf_ram.sv
module ihf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: src/ihf_front.sv
module ihf_front import ihf_pkg::*; #(
  parameter int unsigned RecordBytes = DefaultRecordBytes
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ihf_in_t  item_i,
  output ihf_cmd_t cmd_o
);

  localparam logic [CountW-1:0] RecLimit = CountW'(RecordBytes);

  logic [CountW-1:0] pc_q, pc_d;
  logic [31:0]       rsa_q, rsa_d;
  logic [31:0]       nea_q, nea_d;
  logic [15:0]       lu_q, lu_d;
  logic              hs_q, hs_d;

  always_comb begin
    logic              fa;
    logic              fb;
    logic              ext_a;
    logic              ext_b;
    logic [CountW-1:0] pc1;
    logic [CountW-1:0] pc2;
    logic [31:0]       start;
    logic [15:0]       lu1;

    ext_a = rsa_q[31:16] != lu_q;
    fa    = (pc_q != '0) && (item_i.func || (item_i.byte_address != nea_q));
    lu1   = (fa && ext_a) ? rsa_q[31:16] : lu_q;
    pc1   = fa ? '0 : pc_q;
    start = (pc1 == '0) ? item_i.byte_address : rsa_q;
    pc2   = pc1 + CountW'(1);
    fb    = !item_i.func && ((pc2 >= RecLimit) || (item_i.byte_address == '1));
    ext_b = start[31:16] != lu1;

    cmd_o.hdr     = !hs_q;
    cmd_o.fa      = fa;
    cmd_o.ext_a   = ext_a;
    cmd_o.upper_a = rsa_q[31:16];
    cmd_o.addr_a  = rsa_q[15:0];
    cmd_o.cnt_a   = pc_q;
    cmd_o.wr      = !item_i.func;
    cmd_o.wr_idx  = pc1[IndexW-1:0];
    cmd_o.data    = item_i.data_byte;
    cmd_o.fb      = fb;
    cmd_o.ext_b   = ext_b;
    cmd_o.upper_b = start[31:16];
    cmd_o.addr_b  = start[15:0];
    cmd_o.cnt_b   = pc2;
    cmd_o.eof     = item_i.func;

    if (item_i.func) begin
      pc_d  = '0;
      rsa_d = '0;
      nea_d = '0;
      lu_d  = '0;
      hs_d  = 1'b0;
    end else begin
      pc_d  = fb ? '0 : pc2;
      rsa_d = start;
      nea_d = item_i.byte_address + 32'd1;
      lu_d  = (fb && ext_b) ? start[31:16] : lu1;
      hs_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      rsa_q <= '0;
      nea_q <= '0;
      lu_q  <= '0;
      hs_q  <= 1'b0;
    end else if (push_i) begin
      pc_q  <= pc_d;
      rsa_q <= rsa_d;
      nea_q <= nea_d;
      lu_q  <= lu_d;
      hs_q  <= hs_d;
    end
  end

  // An open record never reaches the record size; it is flushed first.
  a_pending_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q < RecLimit)
    else $error("open record holds a full record of bytes");

  // No byte can be held before the opening extended address record.
  a_no_bytes_before_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hs_q |-> (pc_q == '0))
    else $error("bytes held before the header record");

endmodule

FILE: src/ihf_cmd_queue.sv
module ihf_cmd_queue import ihf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ihf_cmd_t cmd_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output ihf_cmd_t cmd_o
);

  localparam int unsigned Depth = 2 ** QueueAw;

  ihf_cmd_t            entries_q [Depth];
  logic [QueueAw-1:0]  wr_ptr_q;
  logic [QueueAw-1:0]  rd_ptr_q;
  logic [QueueAw:0]    count_q;

  assign full_o  = count_q == (QueueAw + 1)'(Depth);
  assign valid_o = count_q != '0;
  assign cmd_o   = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueueAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueueAw'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QueueAw + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QueueAw + 1)'(1);
      end
    end
  end

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QueueAw + 1)'(Depth))
    else $error("command queue count out of range");

endmodule

FILE: src/ihf_back.sv
module ihf_back import ihf_pkg::*; #(
  parameter int unsigned RecordBytes = DefaultRecordBytes
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  ihf_cmd_t cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  output ihf_out_t out_item_o,
  input  logic     out_stall_i
);

  localparam int unsigned BufAw = (RecordBytes > 1) ? $clog2(RecordBytes) : 1;
  localparam logic [ResultCntW-1:0] ResultLimit = ResultCntW'(MaxResults);
  localparam logic [6:0] OutSegs = 7'b111_0111;

  typedef enum logic [2:0] {
    SIdle, SHdr, SExtA, SRecA, SWr, SExtB, SRecB, SEof
  } state_e;

  function automatic logic [6:0] seg_mask(input ihf_cmd_t c);
    seg_mask = {c.eof, c.fb, c.fb & c.ext_b, c.wr, c.fa, c.fa & c.ext_a, c.hdr};
  endfunction

  function automatic state_e first_seg(input logic [6:0] m);
    if (m[0]) begin
      first_seg = SHdr;
    end else if (m[1]) begin
      first_seg = SExtA;
    end else if (m[2]) begin
      first_seg = SRecA;
    end else if (m[3]) begin
      first_seg = SWr;
    end else if (m[4]) begin
      first_seg = SExtB;
    end else if (m[5]) begin
      first_seg = SRecB;
    end else if (m[6]) begin
      first_seg = SEof;
    end else begin
      first_seg = SIdle;
    end
  endfunction

  function automatic logic [6:0] seg_bit(input state_e s);
    case (s)
      SHdr:    seg_bit = 7'b000_0001;
      SExtA:   seg_bit = 7'b000_0010;
      SRecA:   seg_bit = 7'b000_0100;
      SWr:     seg_bit = 7'b000_1000;
      SExtB:   seg_bit = 7'b001_0000;
      SRecB:   seg_bit = 7'b010_0000;
      SEof:    seg_bit = 7'b100_0000;
      default: seg_bit = 7'b000_0000;
    endcase
  endfunction

  state_e            state_q;
  logic [6:0]        todo_q;
  ihf_cmd_t          cmd_q;
  logic [PosW-1:0]   pos_q;
  logic [PosW-1:0]   pos_d;
  logic [7:0]        sum_q;
  logic [ResultCntW-1:0] ocnt_q;
  logic              out_valid_q;
  ihf_out_t          out_q;

  logic [6:0]      rest;
  logic [7:0]      r_count;
  logic [15:0]     r_addr;
  logic [7:0]      r_type;
  logic [15:0]     r_upper;
  logic            r_from_buf;
  logic [PosW-1:0] r_len;
  logic            emitting;
  logic            adv;
  logic            at_check;
  logic            final_byte;
  logic            seg_done;
  logic [7:0]      cur_byte;
  logic [7:0]      buf_rdata;
  logic [PosW-1:0] rd_pos;

  always_comb begin
    r_count    = ExtPayloadBytes;
    r_addr     = '0;
    r_type     = RecTypeExtLinear;
    r_upper    = '0;
    r_from_buf = 1'b0;
    r_len      = PosW'(ExtPayloadBytes);
    case (state_q)
      SExtA: begin
        r_upper = cmd_q.upper_a;
      end
      SRecA: begin
        r_count    = 8'(cmd_q.cnt_a);
        r_addr     = cmd_q.addr_a;
        r_type     = RecTypeData;
        r_from_buf = 1'b1;
        r_len      = PosW'(cmd_q.cnt_a);
      end
      SExtB: begin
        r_upper = cmd_q.upper_b;
      end
      SRecB: begin
        r_count    = 8'(cmd_q.cnt_b);
        r_addr     = cmd_q.addr_b;
        r_type     = RecTypeData;
        r_from_buf = 1'b1;
        r_len      = PosW'(cmd_q.cnt_b);
      end
      SEof: begin
        r_count = '0;
        r_type  = RecTypeEof;
        r_len   = '0;
      end
      default: begin
      end
    endcase
  end

  assign rest       = todo_q & ~seg_bit(state_q);
  assign emitting   = (state_q != SIdle) && (state_q != SWr);
  assign adv        = emitting && (!out_valid_q || !out_stall_i);
  assign at_check   = pos_q == (RecHeadBytes + r_len);
  assign final_byte = at_check && ((rest & OutSegs) == '0);
  assign seg_done   = (adv && at_check) || (state_q == SWr);
  assign pop_o      = cmd_valid_i && ((state_q == SIdle) || (seg_done && (rest == '0)));
  assign pos_d      = adv ? (at_check ? '0 : pos_q + PosW'(1)) : pos_q;
  assign rd_pos     = pos_d - RecHeadBytes;

  always_comb begin
    if (at_check) begin
      cur_byte = 8'(~sum_q + 8'd1);
    end else begin
      case (pos_q)
        PosW'(0): cur_byte = r_count;
        PosW'(1): cur_byte = r_addr[15:8];
        PosW'(2): cur_byte = r_addr[7:0];
        PosW'(3): cur_byte = r_type;
        PosW'(4): cur_byte = r_from_buf ? buf_rdata : r_upper[15:8];
        default:  cur_byte = r_from_buf ? buf_rdata : r_upper[7:0];
      endcase
    end
  end

  ihf_ram #(
    .Width (8),
    .Depth (RecordBytes)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (state_q == SWr),
    .waddr_i (cmd_q.wr_idx[BufAw-1:0]),
    .wdata_i (cmd_q.data),
    .raddr_i (rd_pos[BufAw-1:0]),
    .rdata_o (buf_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      todo_q      <= '0;
      cmd_q       <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      ocnt_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (adv && (ocnt_q < ResultLimit)) begin
        out_valid_q        <= 1'b1;
        out_q.record_byte  <= cur_byte;
        out_q.record_start <= pos_q == '0;
        out_q.last         <= final_byte || (ocnt_q == ResultLimit - ResultCntW'(1));
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (adv) begin
        sum_q <= (pos_q == '0) ? cur_byte : sum_q + cur_byte;
      end
      if (pop_o) begin
        cmd_q   <= cmd_i;
        todo_q  <= seg_mask(cmd_i);
        state_q <= first_seg(seg_mask(cmd_i));
        pos_q   <= '0;
        ocnt_q  <= '0;
      end else begin
        pos_q <= pos_d;
        if (adv && (ocnt_q < ResultLimit)) begin
          ocnt_q <= ocnt_q + ResultCntW'(1);
        end
        if (seg_done) begin
          todo_q  <= rest;
          state_q <= first_seg(rest);
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_idle_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> (todo_q == '0))
    else $error("sequencer idle with segments still pending");

  a_current_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> ((todo_q & seg_bit(state_q)) != '0))
    else $error("current segment not in the pending set");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitting |-> (pos_q <= (RecHeadBytes + r_len)))
    else $error("byte position passed the checksum");

endmodule

FILE: src/intel_hex_record_framer_unit.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid_i/in_stall_o  ihf_in_t: func, byte_address, data_byte
// out      output     out_valid_o/out_stall_i ihf_out_t: record_byte, record_start, last
//
// The front classifies one item per cycle into a two-entry command queue unless the queue is full.
// The back spends one cycle per record byte while the output is not stalled, and the buffer write of a
// data item takes a state of its own; an end marker costs only its record bytes.
// From an empty queue the command passes through the queue entry and the back's command register
// before the first record byte is registered at the output.
// Reset is asynchronous and active low; the record buffer needs no clearing.
// A stalled output transfer holds the back, and a full queue stalls the input.
module intel_hex_record_framer_unit import ihf_pkg::*; #(
  parameter int unsigned RecordBytes = DefaultRecordBytes
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ihf_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ihf_out_t out_item_o
);

  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     pop;
  ihf_cmd_t front_cmd;
  ihf_cmd_t back_cmd;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  ihf_front #(
    .RecordBytes (RecordBytes)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (in_item_i),
    .cmd_o  (front_cmd)
  );

  ihf_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .cmd_o   (back_cmd)
  );

  ihf_back #(
    .RecordBytes (RecordBytes)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (back_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

FILE: sim/tb_intel_hex_record_framer_unit.sv
`timescale 1ns / 1ps

module tb_intel_hex_record_framer_unit;
  import ihf_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int          RandomItems = 110;
  localparam int          TailItems   = 25;
  localparam int          DrainCycles = 60;
  localparam int          MaxReported = 30;

  localparam logic FuncData = 1'b0;
  localparam logic FuncEnd  = 1'b1;

  localparam logic [55:0] HeaderRecord =
    {ExtPayloadBytes, 16'h0000, RecTypeExtLinear, 16'h0000, 8'hFA};
  localparam logic [39:0] EofRecord = {8'h00, 16'h0000, RecTypeEof, 8'hFF};

  typedef struct packed {
    logic             func;
    logic [31:0]      addr;
    logic [7:0]       data;
    logic [4:0]       n_bytes;
    logic [0:19][7:0] bytes;
  } stim_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  ihf_in_t  in_item_i;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  ihf_out_t out_item_o;

  intel_hex_record_framer_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  stim_row_t directed_rows[$];
  ihf_in_t   random_items[$];
  ihf_out_t  expected_bytes[$];

  logic [7:0]  rec_buf[MaxRecordBytes];
  int unsigned held;
  logic [31:0] rec_base;
  logic [31:0] next_addr;
  logic [15:0] announced_upper;
  bit          opened;
  logic [7:0]  rec_sum;
  int unsigned item_results;

  int mismatch_count;
  int checked_bytes;
  int record_count;
  int items_sent;
  int cycle_count;
  int in_idle_pct;
  int out_idle_pct;
  int stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_framer();
    held            = 0;
    rec_base        = '0;
    next_addr       = '0;
    announced_upper = '0;
    opened          = 1'b0;
  endfunction

  function automatic void emit_byte(logic [7:0] b, bit first);
    ihf_out_t r;
    if (first) begin
      rec_sum = '0;
    end
    rec_sum = rec_sum + b;
    if (item_results < MaxResults) begin
      r.record_byte  = b;
      r.record_start = first;
      r.last         = 1'b0;
      expected_bytes.push_back(r);
      item_results++;
    end
  endfunction

  function automatic void emit_sum();
    logic [7:0] c;
    c = ~rec_sum + 8'd1;
    emit_byte(c, 1'b0);
  endfunction

  function automatic void emit_upper(logic [15:0] upper);
    emit_byte(ExtPayloadBytes, 1'b1);
    emit_byte(8'h00, 1'b0);
    emit_byte(8'h00, 1'b0);
    emit_byte(RecTypeExtLinear, 1'b0);
    emit_byte(upper[15:8], 1'b0);
    emit_byte(upper[7:0], 1'b0);
    emit_sum();
    announced_upper = upper;
  endfunction

  function automatic void flush_record();
    if (held == 0) begin
      return;
    end
    if (rec_base[31:16] != announced_upper) begin
      emit_upper(rec_base[31:16]);
    end
    emit_byte(8'(held), 1'b1);
    emit_byte(rec_base[15:8], 1'b0);
    emit_byte(rec_base[7:0], 1'b0);
    emit_byte(RecTypeData, 1'b0);
    for (int k = 0; k < held; k++) begin
      emit_byte(rec_buf[k], 1'b0);
    end
    emit_sum();
    held = 0;
  endfunction

  // Works out the record bytes that one accepted input transfer causes, keeping up to MaxResults of them.
  function automatic void frame_item(ihf_in_t item);
    ihf_out_t tail;
    item_results = 0;
    if (!opened) begin
      emit_upper(16'h0000);
      opened = 1'b1;
    end
    if (item.func == FuncEnd) begin
      flush_record();
      emit_byte(8'h00, 1'b1);
      emit_byte(8'h00, 1'b0);
      emit_byte(8'h00, 1'b0);
      emit_byte(RecTypeEof, 1'b0);
      emit_sum();
      clear_framer();
    end else begin
      if (held != 0 && item.byte_address != next_addr) begin
        flush_record();
      end
      if (held == 0) begin
        rec_base = item.byte_address;
      end
      if (held < MaxRecordBytes) begin
        rec_buf[held] = item.data_byte;
      end
      held++;
      next_addr = item.byte_address + 32'd1;
      if (held >= DefaultRecordBytes || next_addr == '0) begin
        flush_record();
      end
    end
    if (item_results > 0) begin
      tail      = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_output(ihf_out_t got);
    ihf_out_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("record byte %02h with nothing expected", got.record_byte));
      return;
    end
    want = expected_bytes.pop_front();
    checked_bytes++;
    if (got.record_start) begin
      record_count++;
    end
    if (got.record_byte !== want.record_byte) begin
      report_mismatch($sformatf("record_byte %02h, expected %02h",
                                got.record_byte, want.record_byte));
    end
    if (got.record_start !== want.record_start) begin
      report_mismatch($sformatf("record_start %b, expected %b on byte %02h",
                                got.record_start, want.record_start, want.record_byte));
    end
    if (got.last !== want.last) begin
      report_mismatch($sformatf("last %b, expected %b on byte %02h",
                                got.last, want.last, want.record_byte));
    end
  endtask

  task automatic add_row(logic func, logic [31:0] addr, logic [7:0] data,
                         logic [4:0] n_bytes, logic [0:19][7:0] bytes);
    stim_row_t row;
    row.func    = func;
    row.addr    = addr;
    row.data    = data;
    row.n_bytes = n_bytes;
    row.bytes   = bytes;
    directed_rows.push_back(row);
  endtask

  function automatic logic [31:0] pick_base();
    logic [31:0] base;
    case ($urandom_range(0, 3))
      0: base = $urandom;
      1: base = {16'($urandom), 16'hFFF0} + $urandom_range(0, 15);
      2: base = 32'hFFFF_FFE0 + $urandom_range(0, 31);
      default: base = $urandom_range(0, 64);
    endcase
    return base;
  endfunction

  function automatic int pick_idle_pct();
    int pct;
    case ($urandom_range(0, 2))
      0: pct = 0;
      1: pct = 10;
      default: pct = 40;
    endcase
    return pct;
  endfunction

  // Images are mostly contiguous runs with random content; backward steps,
  // far jumps and empty images supply the broken and unusual sequences.
  task automatic build_random_items();
    logic [31:0] addr;
    int          runs;
    int          run_len;
    ihf_in_t     it;
    while (random_items.size() < RandomItems) begin
      runs = $urandom_range(1, 4);
      addr = pick_base();
      for (int r = 0; r < runs; r++) begin
        run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 40) : $urandom_range(1, 12);
        for (int k = 0; k < run_len; k++) begin
          it.func         = FuncData;
          it.byte_address = addr;
          it.data_byte    = 8'($urandom);
          random_items.push_back(it);
          addr = addr + 32'd1;
        end
        case ($urandom_range(0, 9))
          0: addr = addr - $urandom_range(1, 3);
          1, 2: addr = pick_base();
          default: addr = addr + $urandom_range(1, 600);
        endcase
      end
      it.func         = FuncEnd;
      it.byte_address = $urandom;
      it.data_byte    = 8'($urandom);
      random_items.push_back(it);
      if ($urandom_range(0, 7) == 0) begin
        random_items.push_back(it);
      end
    end
    while (random_items.size() >= RandomItems) begin
      void'(random_items.pop_back());
    end
    it.func         = FuncEnd;
    it.byte_address = $urandom;
    it.data_byte    = 8'($urandom);
    random_items.push_back(it);
  endtask

  task automatic push_item(ihf_in_t item);
    if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_output(out_item_o);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
      stall_left = $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
    end
    $display("timeout after %0d cycles, %0d record bytes outstanding",
             cycle_count, expected_bytes.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    stim_row_t row;
    ihf_in_t   item;
    ihf_out_t  want;
    int        queued;
    int        next_start;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    in_idle_pct  = 0;
    out_idle_pct = 0;
    clear_framer();

    add_row(FuncEnd,  32'hFFFF_FFFF, 8'hFF, 5'd12, {HeaderRecord, EofRecord, 64'h0});
    add_row(FuncData, 32'hFFFF_FFFF, 8'h00, 5'd20,
            {HeaderRecord,
             ExtPayloadBytes, 16'h0000, RecTypeExtLinear, 16'hFFFF, 8'hFC,
             8'h01, 16'hFFFF, RecTypeData, 8'h00, 8'h01});
    add_row(FuncEnd,  32'h0000_0000, 8'h00, 5'd5,  {EofRecord, 120'h0});
    add_row(FuncData, 32'h0000_0000, 8'hFF, 5'd0, '0);
    add_row(FuncData, 32'h0000_0001, 8'h00, 5'd0, '0);
    add_row(FuncData, 32'h0001_FFF0, 8'hA5, 5'd0, '0);
    add_row(FuncData, 32'h0001_FFF1, 8'h5A, 5'd0, '0);
    add_row(FuncData, 32'h0001_FFF1, 8'h3C, 5'd0, '0);
    add_row(FuncData, 32'h0000_0010, 8'hC3, 5'd0, '0);
    add_row(FuncData, 32'h0000_FFFF, 8'h81, 5'd0, '0);
    add_row(FuncData, 32'h0001_0000, 8'h7E, 5'd0, '0);
    add_row(FuncData, 32'h0001_0001, 8'h01, 5'd0, '0);
    add_row(FuncData, 32'hFFFF_FFFE, 8'h80, 5'd0, '0);
    add_row(FuncData, 32'hFFFF_FFFF, 8'h7F, 5'd0, '0);
    add_row(FuncData, 32'h0000_0000, 8'h55, 5'd0, '0);
    add_row(FuncData, 32'hAAAA_AAAA, 8'hAA, 5'd0, '0);
    add_row(FuncData, 32'h5555_5555, 8'h55, 5'd0, '0);
    add_row(FuncEnd,  32'h5A5A_5A5A, 8'hC3, 5'd0, '0);
    add_row(FuncEnd,  32'h0000_0000, 8'h00, 5'd12, {HeaderRecord, EofRecord, 64'h0});
    build_random_items();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_idle_pct  = 20;
    out_idle_pct = 20;
    foreach (directed_rows[i]) begin
      row               = directed_rows[i];
      item.func         = row.func;
      item.byte_address = row.addr;
      item.data_byte    = row.data;
      push_item(item);
      queued = expected_bytes.size();
      frame_item(item);
      if (row.n_bytes != 0) begin
        while (expected_bytes.size() > queued) begin
          void'(expected_bytes.pop_back());
        end
        next_start = 0;
        for (int k = 0; k < row.n_bytes; k++) begin
          want.record_byte  = row.bytes[k];
          want.record_start = (k == next_start);
          want.last         = (k == row.n_bytes - 1);
          if (want.record_start) begin
            next_start = k + row.bytes[k] + 5;
          end
          expected_bytes.push_back(want);
        end
      end
    end

    // The sender holds off until every record byte so far has been transferred.
    in_valid_i <= 1'b0;
    while (expected_bytes.size() != 0) begin
      @(posedge clk_i);
    end

    foreach (random_items[i]) begin
      if (i % 20 == 0) begin
        in_idle_pct  = pick_idle_pct();
        out_idle_pct = pick_idle_pct();
      end
      if (i >= random_items.size() - TailItems) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      if (i == random_items.size() / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (expected_bytes.size() != 0) begin
          @(posedge clk_i);
        end
      end
      push_item(random_items[i]);
      frame_item(random_items[i]);
    end
    in_valid_i <= 1'b0;

    while (expected_bytes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d input items (%0d from the directed table), %0d records",
             items_sent, directed_rows.size(), record_count);
    $display("checked %0d record bytes, %0d mismatches", checked_bytes, mismatch_count);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ihf_pkg.sv
src/ihf_ram.sv
src/ihf_front.sv
src/ihf_cmd_queue.sv
src/ihf_back.sv
src/intel_hex_record_framer_unit.sv
sim/tb_intel_hex_record_framer_unit.sv
